### rtl/terminal_display_width_counter_macros.svh
// Assertion macros for the display width counter checker.
// Included by the checker file; no other dependencies.
`ifndef TERMINAL_DISPLAY_WIDTH_COUNTER_MACROS_SVH
`define TERMINAL_DISPLAY_WIDTH_COUNTER_MACROS_SVH

// Clocked assertion, disabled while reset is asserted
`define TDWC_ASSERT(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) expr) else $error(msg);

// Clocked assertion that is also checked during reset
`define TDWC_ASSERT_ALWAYS(lbl, clk, expr, msg) \
    lbl: assert property (@(posedge clk) expr) else $error(msg);

`endif

### rtl/tdwc_pkg.sv
// Package for the terminal display width counter: byte codes and defaults.
// No dependencies.
package tdwc_pkg;

    // default width of the internal column counter
    localparam int COUNT_BITS_DEF = 16;
    // width of the reported column count
    localparam int OUT_BITS = 16;

    // tab width after reset
    localparam logic [3:0] TAB_WIDTH_RST = 4'd4;

    // special bytes
    localparam logic [7:0] BYTE_BS       = 8'h08;
    localparam logic [7:0] BYTE_TAB      = 8'h09;
    localparam logic [7:0] BYTE_ESC      = 8'h1B;
    localparam logic [7:0] BYTE_LBRACKET = 8'h5B;
    localparam logic [7:0] BYTE_M        = 8'h6D;

    // printable ASCII range
    localparam logic [7:0] PRINT_LO = 8'h20;
    localparam logic [7:0] PRINT_HI = 8'h7E;

    // UTF-8 lead byte ranges
    localparam logic [7:0] UTF2_LO = 8'hC2;
    localparam logic [7:0] UTF2_HI = 8'hDF;
    localparam logic [7:0] UTF3_LO = 8'hE0;
    localparam logic [7:0] UTF3_HI = 8'hEF;
    localparam logic [7:0] UTF4_LO = 8'hF0;
    localparam logic [7:0] UTF4_HI = 8'hF4;

endpackage

### rtl/terminal_display_width_counter.sv
// Terminal display width counter: top level, single registered pass per byte.
// Depends on tdwc_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one byte of a string per
//   transfer, with i_last marking the final byte. Output channel
//   (o_out_valid / i_out_stall) carries one result per string: the column
//   count o_display_width and the o_saturated flag.
//   One byte is taken every cycle while o_in_stall is low; each byte updates
//   the count, the escape parser mode and the UTF-8 skip counter.
//   The result is registered, valid in the cycle after the last byte is taken.
//   The output register holds the result while i_out_stall is high; input is
//   then stalled only while a result waits and the receiver stalls.
//   Reset (synchronous, i_rst_n low) clears the count, parser and output
//   valid, and sets the tab width to 4. Write the tab width with i_cfg_we
//   and i_cfg_data while no string is in progress.
module terminal_display_width_counter #(
    parameter int COUNT_BITS = tdwc_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [3:0]                    i_cfg_data,
    // byte input
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_char_byte,
    input  logic                          i_last,
    // result output
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tdwc_pkg::OUT_BITS-1:0] o_display_width,
    output logic                          o_saturated
);

    localparam int OB = tdwc_pkg::OUT_BITS;

    // parser modes
    localparam logic [1:0] MODE_TEXT = 2'd0;
    localparam logic [1:0] MODE_ESC  = 2'd1;
    localparam logic [1:0] MODE_CSI  = 2'd2;
    localparam logic [1:0] MODE_SKIP = 2'd3;

    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [1:0]            r_mode, n_mode;
    logic [1:0]            r_skip, n_skip;
    logic                  r_ovf, n_ovf;
    logic [3:0]            r_tab;
    logic                  r_out_valid;
    logic [OB-1:0]         r_display_width;
    logic                  r_saturated;

    logic                  accept;
    logic                  do_text;
    logic                  add_en;
    logic [3:0]            add_amt;
    logic [COUNT_BITS:0]   sum;
    logic                  clipped;
    logic [OB-1:0]         width_out;

    // stall only while a result waits and the receiver stalls
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    // parser mode and skip counter
    always_comb begin
        n_mode  = r_mode;
        n_skip  = r_skip;
        do_text = 1'b0;
        unique case (r_mode)
            MODE_ESC: begin
                if (i_char_byte == tdwc_pkg::BYTE_LBRACKET) begin
                    n_mode = MODE_CSI;
                end else begin
                    n_mode  = MODE_TEXT;
                    do_text = 1'b1;
                end
            end
            MODE_CSI: begin
                if (i_char_byte == tdwc_pkg::BYTE_M) begin
                    n_mode = MODE_TEXT;
                end
            end
            MODE_SKIP: begin
                if (r_skip != 2'd0) begin
                    n_skip = r_skip - 2'd1;
                end
                if (n_skip == 2'd0) begin
                    n_mode = MODE_TEXT;
                end
            end
            default: begin
                n_mode  = MODE_TEXT;
                do_text = 1'b1;
            end
        endcase

        // ordinary text byte decode
        add_en  = 1'b0;
        add_amt = 4'd1;
        if (do_text) begin
            priority if (i_char_byte >= tdwc_pkg::PRINT_LO
                         && i_char_byte <= tdwc_pkg::PRINT_HI) begin
                add_en = 1'b1;
            end else if (i_char_byte == tdwc_pkg::BYTE_TAB) begin
                add_en  = 1'b1;
                add_amt = r_tab;
            end else if (i_char_byte == tdwc_pkg::BYTE_ESC) begin
                n_mode = MODE_ESC;
            end else if (i_char_byte >= tdwc_pkg::UTF2_LO
                         && i_char_byte <= tdwc_pkg::UTF2_HI) begin
                add_en = 1'b1;
                n_mode = MODE_SKIP;
                n_skip = 2'd1;
            end else if (i_char_byte >= tdwc_pkg::UTF3_LO
                         && i_char_byte <= tdwc_pkg::UTF3_HI) begin
                add_en = 1'b1;
                n_mode = MODE_SKIP;
                n_skip = 2'd2;
            end else if (i_char_byte >= tdwc_pkg::UTF4_LO
                         && i_char_byte <= tdwc_pkg::UTF4_HI) begin
                add_en = 1'b1;
                n_mode = MODE_SKIP;
                n_skip = 2'd3;
            end else begin
                add_en = 1'b0;
            end
        end
    end

    // column count: saturating add, backspace floors at zero
    assign sum = {1'b0, r_count} + (COUNT_BITS + 1)'(add_amt);

    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        if (do_text && i_char_byte == tdwc_pkg::BYTE_BS) begin
            if (r_count != '0) begin
                n_count = r_count - COUNT_BITS'(1);
            end
        end else if (add_en) begin
            if (sum[COUNT_BITS]) begin
                n_count = '1;
                n_ovf   = 1'b1;
            end else begin
                n_count = sum[COUNT_BITS-1:0];
            end
        end
    end

    // clip the count to the reported width
    generate
        if (COUNT_BITS > OB) begin : g_clip
            assign clipped   = |n_count[COUNT_BITS-1:OB];
            assign width_out = clipped ? '1 : n_count[OB-1:0];
        end else begin : g_noclip
            assign clipped   = 1'b0;
            assign width_out = OB'(n_count);
        end
    endgenerate

    // parser state and tab width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_mode  <= MODE_TEXT;
            r_skip  <= 2'd0;
            r_ovf   <= 1'b0;
            r_tab   <= tdwc_pkg::TAB_WIDTH_RST;
        end else begin
            if (i_cfg_we) begin
                r_tab <= i_cfg_data;
            end
            if (accept) begin
                if (i_last) begin
                    r_count <= '0;
                    r_mode  <= MODE_TEXT;
                    r_skip  <= 2'd0;
                    r_ovf   <= 1'b0;
                end else begin
                    r_count <= n_count;
                    r_mode  <= n_mode;
                    r_skip  <= n_skip;
                    r_ovf   <= n_ovf;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_out_valid <= accept && i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_last) begin
            r_display_width <= width_out;
            r_saturated     <= n_ovf || clipped;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_display_width = r_display_width;
    assign o_saturated     = r_saturated;

endmodule

### rtl/tdwc_checker.sv
// Port-level checker for the terminal display width counter, bound to the top.
// Depends on tdwc_pkg and terminal_display_width_counter_macros.svh.
`include "terminal_display_width_counter_macros.svh"

module tdwc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          i_last,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [tdwc_pkg::OUT_BITS-1:0] o_display_width,
    input logic                          o_saturated
);

    logic in_xfer;
    assign in_xfer = i_in_valid && !o_in_stall;

    // a held result keeps its payload
    `TDWC_ASSERT(a_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_display_width) && $stable(o_saturated), "result changed while stalled")

    // reset empties the output register
    `TDWC_ASSERT_ALWAYS(a_rst, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")

    // the last byte of a string always yields a result
    `TDWC_ASSERT(a_last, i_clk, i_rst_n, in_xfer && i_last |=> o_out_valid, "no result after last byte")

    // a byte that is not last yields no result on an empty output
    `TDWC_ASSERT(a_nolast, i_clk, i_rst_n, in_xfer && !i_last && !o_out_valid |=> !o_out_valid, "result without last byte")

    // input is never stalled while no result waits
    `TDWC_ASSERT(a_stall, i_clk, i_rst_n, !o_out_valid |-> !o_in_stall, "input stalled with empty output")

endmodule

bind terminal_display_width_counter tdwc_checker u_tdwc_checker (.*);

### tb/tb_top.sv
// Testbench for terminal_display_width_counter: directed strings, then random strings
// checked against a column-count predictor. Depends on tdwc_pkg and the counter RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // parser state of the predictor
    typedef enum logic [1:0] {SCAN_TEXT, SCAN_ESC, SCAN_CSI, SCAN_SKIP} t_scan_mode;

    typedef struct packed {
        logic [tdwc_pkg::OUT_BITS-1:0] width;
        logic                          sat;
    } t_col_result;

    // one row of the directed string table; typed rows carry their expected result
    typedef struct packed {
        logic [7:0]  chr;
        logic        fin;
        logic        typed;
        logic [15:0] width;
        logic        sat;
    } t_dir_row;

    localparam longint unsigned COL_LIMIT = (64'd1 << tdwc_pkg::COUNT_BITS_DEF) - 1;
    localparam longint unsigned OUT_MAX   = (64'd1 << tdwc_pkg::OUT_BITS) - 1;
    localparam int              PHASE_BYTES = 200;

    localparam logic [3:0] TAB_STEPS [8] = '{4'd0, 4'd15, 4'd1, 4'd8, 4'd10, 4'd5, 4'd4, 4'd15};

    localparam t_dir_row DIR_ROWS [27] = '{
        '{tdwc_pkg::PRINT_HI,      1'b1, 1'b1, 16'd1, 1'b0},  // single printable after reset
        '{tdwc_pkg::BYTE_BS,       1'b1, 1'b1, 16'd0, 1'b0},  // backspace at zero holds
        '{tdwc_pkg::PRINT_LO,      1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h1F,                   1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h7F,                   1'b0, 1'b0, 16'd0, 1'b0},
        '{tdwc_pkg::BYTE_TAB,      1'b1, 1'b1, 16'd5, 1'b0},  // default tab is 4
        '{tdwc_pkg::BYTE_ESC,      1'b0, 1'b0, 16'd0, 1'b0},
        '{tdwc_pkg::BYTE_LBRACKET, 1'b0, 1'b0, 16'd0, 1'b0},
        '{tdwc_pkg::BYTE_M,        1'b1, 1'b1, 16'd0, 1'b0},  // sequence closes on last byte
        '{tdwc_pkg::BYTE_ESC,      1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h41,                   1'b1, 1'b1, 16'd1, 1'b0},  // ESC without '[' is text
        '{tdwc_pkg::UTF2_LO,       1'b0, 1'b0, 16'd0, 1'b0},
        '{tdwc_pkg::BYTE_ESC,      1'b0, 1'b0, 16'd0, 1'b0},  // swallowed by the UTF-8 skip
        '{8'h21,                   1'b1, 1'b0, 16'd0, 1'b0},
        '{tdwc_pkg::UTF3_LO,       1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h80,                   1'b0, 1'b0, 16'd0, 1'b0},
        '{8'hBF,                   1'b1, 1'b0, 16'd0, 1'b0},
        '{tdwc_pkg::UTF4_HI,       1'b0, 1'b0, 16'd0, 1'b0},
        '{8'hFF,                   1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h00,                   1'b0, 1'b0, 16'd0, 1'b0},
        '{tdwc_pkg::PRINT_HI,      1'b1, 1'b0, 16'd0, 1'b0},
        '{8'hC1,                   1'b0, 1'b0, 16'd0, 1'b0},  // not a lead byte
        '{8'hF5,                   1'b0, 1'b0, 16'd0, 1'b0},  // not a lead byte
        '{tdwc_pkg::UTF2_HI,       1'b1, 1'b0, 16'd0, 1'b0},  // string ends with a skip open
        '{tdwc_pkg::UTF3_HI,       1'b1, 1'b1, 16'd1, 1'b0},  // parser back in text mode
        '{tdwc_pkg::BYTE_ESC,      1'b0, 1'b0, 16'd0, 1'b0},
        '{tdwc_pkg::BYTE_ESC,      1'b1, 1'b1, 16'd0, 1'b0}   // ESC followed by ESC
    };

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [3:0]                    i_cfg_data = 4'd0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic [7:0]                    i_char_byte = 8'd0;
    logic                          i_last = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic [tdwc_pkg::OUT_BITS-1:0] o_display_width;
    logic                          o_saturated;

    // predictor state
    longint unsigned col_count = 0;
    t_scan_mode      scan_mode = SCAN_TEXT;
    int unsigned     skip_left = 0;
    logic            col_ovf = 1'b0;
    logic [3:0]      tab_cfg = tdwc_pkg::TAB_WIDTH_RST;

    t_col_result pending_widths [$];
    int          err_count  = 0;
    int          bytes_sent = 0;
    int          stall_left = 0;
    bit          calm = 1'b0;

    terminal_display_width_counter u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_char_byte     (i_char_byte),
        .i_last          (i_last),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_display_width (o_display_width),
        .o_saturated     (o_saturated)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic flag_mismatch(string what, longint got, longint want);
        $display("tb_top: mismatch on %s, got %0d, want %0d, at %0t", what, got, want, $time);
        err_count++;
    endtask

    // add columns, holding at the counter limit
    function automatic void add_cols(longint unsigned n);
        if (n > COL_LIMIT - col_count) begin
            col_count = COL_LIMIT;
            col_ovf   = 1'b1;
        end else begin
            col_count += n;
        end
    endfunction

    // one byte seen in text mode
    function automatic void text_char(logic [7:0] chr);
        if (chr >= tdwc_pkg::PRINT_LO && chr <= tdwc_pkg::PRINT_HI) begin
            add_cols(1);
        end else if (chr == tdwc_pkg::BYTE_BS) begin
            if (col_count != 0) col_count--;
        end else if (chr == tdwc_pkg::BYTE_TAB) begin
            add_cols(tab_cfg);
        end else if (chr == tdwc_pkg::BYTE_ESC) begin
            scan_mode = SCAN_ESC;
        end else if (chr >= tdwc_pkg::UTF2_LO && chr <= tdwc_pkg::UTF2_HI) begin
            add_cols(1);
            scan_mode = SCAN_SKIP;
            skip_left = 1;
        end else if (chr >= tdwc_pkg::UTF3_LO && chr <= tdwc_pkg::UTF3_HI) begin
            add_cols(1);
            scan_mode = SCAN_SKIP;
            skip_left = 2;
        end else if (chr >= tdwc_pkg::UTF4_LO && chr <= tdwc_pkg::UTF4_HI) begin
            add_cols(1);
            scan_mode = SCAN_SKIP;
            skip_left = 3;
        end
    endfunction

    // predictor step: one accepted byte, result on the last byte of a string
    function automatic void count_byte(input logic [7:0] chr, input logic fin,
                                       output logic produced, output t_col_result res);
        produced = 1'b0;
        res      = '0;
        case (scan_mode)
            SCAN_ESC: begin
                if (chr == tdwc_pkg::BYTE_LBRACKET) begin
                    scan_mode = SCAN_CSI;
                end else begin
                    scan_mode = SCAN_TEXT;
                    text_char(chr);
                end
            end
            SCAN_CSI: begin
                if (chr == tdwc_pkg::BYTE_M) scan_mode = SCAN_TEXT;
            end
            SCAN_SKIP: begin
                if (skip_left != 0) skip_left--;
                if (skip_left == 0) scan_mode = SCAN_TEXT;
            end
            default: begin
                scan_mode = SCAN_TEXT;
                text_char(chr);
            end
        endcase
        if (fin) begin
            produced = 1'b1;
            if (col_count > OUT_MAX) begin
                res.width = '1;
                res.sat   = 1'b1;
            end else begin
                res.width = col_count[tdwc_pkg::OUT_BITS-1:0];
                res.sat   = col_ovf;
            end
            col_count = 0;
            scan_mode = SCAN_TEXT;
            skip_left = 0;
            col_ovf   = 1'b0;
        end
    endfunction

    // one byte transfer; valid stays high afterwards for a back-to-back byte
    task automatic send_byte(logic [7:0] chr, logic fin, logic typed, t_col_result want);
        logic        produced;
        t_col_result res;
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_char_byte <= chr;
        i_last      <= fin;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        count_byte(chr, fin, produced, res);
        if (produced) pending_widths = {pending_widths, (typed ? want : res)};
        bytes_sent++;
    endtask

    // tab width write once all results are in and the block has settled
    task automatic set_tab(logic [3:0] cols);
        i_in_valid <= 1'b0;
        while (pending_widths.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= cols;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tab_cfg = cols;
    endtask

    // random string built from tokens; some sequences are left broken
    task automatic send_random_string(int max_tokens);
        logic [7:0] text [$];
        int         n_tok;
        int         kind;
        int         n;
        n_tok = $urandom_range(1, max_tokens);
        for (int t = 0; t < n_tok; t++) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                text = {text, 8'($urandom_range(tdwc_pkg::PRINT_LO, tdwc_pkg::PRINT_HI))};
            end else if (kind < 45) begin
                text = {text, tdwc_pkg::BYTE_BS};
            end else if (kind < 53) begin
                text = {text, tdwc_pkg::BYTE_TAB};
            end else if (kind < 65) begin
                // control sequence, occasionally with stray bytes or unterminated
                text = {text, tdwc_pkg::BYTE_ESC};
                text = {text, tdwc_pkg::BYTE_LBRACKET};
                n = $urandom_range(0, 4);
                repeat (n) begin
                    case ($urandom_range(0, 7))
                        0:       text = {text, 8'h3B};
                        1:       text = {text, 8'($urandom_range(0, 255))};
                        default: text = {text, 8'(8'h30 + $urandom_range(0, 9))};
                    endcase
                end
                if ($urandom_range(0, 9) != 0) text = {text, tdwc_pkg::BYTE_M};
            end else if (kind < 70) begin
                text = {text, tdwc_pkg::BYTE_ESC};
                text = {text, 8'($urandom_range(0, 255))};
            end else if (kind < 85) begin
                // UTF-8 lead byte with its continuation bytes
                case ($urandom_range(0, 2))
                    0: begin
                        text = {text, 8'($urandom_range(tdwc_pkg::UTF2_LO, tdwc_pkg::UTF2_HI))};
                        n = 1;
                    end
                    1: begin
                        text = {text, 8'($urandom_range(tdwc_pkg::UTF3_LO, tdwc_pkg::UTF3_HI))};
                        n = 2;
                    end
                    default: begin
                        text = {text, 8'($urandom_range(tdwc_pkg::UTF4_LO, tdwc_pkg::UTF4_HI))};
                        n = 3;
                    end
                endcase
                repeat (n) begin
                    if ($urandom_range(0, 7) == 0) text = {text, 8'($urandom_range(0, 255))};
                    else text = {text, 8'($urandom_range(8'h80, 8'hBF))};
                end
            end else begin
                text = {text, 8'($urandom_range(0, 255))};
            end
        end
        if (text.size() > 1 && $urandom_range(0, 9) == 0) void'(text.pop_back());
        foreach (text[i]) send_byte(text[i], i == text.size() - 1, 1'b0, '0);
    endtask

    // receiver stall bursts
    always @(posedge i_clk) begin
        if (calm || !i_rst_n) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 7);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_col_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_widths.size() == 0) begin
                flag_mismatch("result with none expected", o_display_width, -1);
            end else begin
                want = pending_widths.pop_front();
                if (o_display_width !== want.width)
                    flag_mismatch("display_width", o_display_width, want.width);
                if (o_saturated !== want.sat)
                    flag_mismatch("saturated", o_saturated, want.sat);
            end
        end
    end

    // run limit
    initial begin
        #3_200_000;
        $display("tb_top: errors");
        $finish;
    end

    // stimulus
    initial begin
        int phase_end;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed strings at the reset tab width
        foreach (DIR_ROWS[i])
            send_byte(DIR_ROWS[i].chr, DIR_ROWS[i].fin, DIR_ROWS[i].typed,
                      '{width: DIR_ROWS[i].width, sat: DIR_ROWS[i].sat});

        // random phases, one tab width each; the last two run without idling
        foreach (TAB_STEPS[p]) begin
            set_tab(p == 4 ? 4'($urandom_range(0, 15)) : TAB_STEPS[p]);
            calm = (p >= 6);
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end) send_random_string(p == 3 ? 40 : 8);
        end

        // drain
        i_in_valid <= 1'b0;
        while (pending_widths.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
